// File: src/qcc_pkg.sv
// qcc_pkg: shared widths, types and the tilt rounding function of the quad-cell centroid core
`timescale 1ns / 1ps

package qcc_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int GRID_BITS  = 6;

  localparam int FLUX_W  = PIXEL_BITS + 2;
  localparam int PAIR_W  = PIXEL_BITS + 1;
  localparam int TILT_W  = 16;
  localparam int SLOT_W  = 13;
  localparam int WIDTH_W = 7;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

  // quotient carries two extra bits: one dropped, one for round half up
  localparam int QUO_W      = TILT_W + 2;
  localparam int REM_W      = FLUX_W + 1;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NSTG       = DIV_STAGES + 3;

  localparam int IN_W        = 4 * PIXEL_BITS + 2 * GRID_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = FLUX_W + 2 * TILT_W + 2 * SLOT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [TILT_W-1:0] TILT_MAX = {1'b0, {(TILT_W-1){1'b1}}};

  typedef struct packed {
    logic [FLUX_W-1:0] flux;
    logic              zf;
    logic              neg_x;
    logic              neg_y;
    logic [SLOT_W-1:0] x_slot;
    logic [SLOT_W-1:0] y_slot;
  } side_t;

  function automatic logic [TILT_W-1:0] tilt_round(input logic [QUO_W-1:0] quo,
                                                   input logic neg,
                                                   input logic zf);
    logic [QUO_W-1:0] sum;
    logic [TILT_W:0]  q;
    logic [TILT_W-1:0] res;
    sum = {1'b0, quo[QUO_W-1:1]} + QUO_W'(1);
    q   = sum[TILT_W+1:1];
    if (zf) begin
      res = '0;
    end else if (neg) begin
      res = ~q[TILT_W-1:0] + TILT_W'(1);
    end else if (q > {1'b0, TILT_MAX}) begin
      res = TILT_MAX;
    end else begin
      res = q[TILT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/qcc_div_stage.sv
// qcc_div_stage: one registered stage of the restoring divider, two quotient bits per stage
`timescale 1ns / 1ps

module qcc_div_stage (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qcc_pkg::REM_W-1:0]  rem_i,
  input  logic [qcc_pkg::QUO_W-1:0]  quo_i,
  input  logic [qcc_pkg::FLUX_W-1:0] div_i,
  output logic [qcc_pkg::REM_W-1:0]  rem_o,
  output logic [qcc_pkg::QUO_W-1:0]  quo_o
);
  import qcc_pkg::*;

  logic [REM_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0] quo_d, quo_q;

  always_comb begin
    logic [REM_W-1:0] r;
    logic [QUO_W-1:0] q;
    logic             ge;
    r = rem_i;
    q = quo_i;
    for (int k = 0; k < DIV_STEPS; k++) begin
      ge = (r >= {1'b0, div_i});
      if (ge) begin
        r = r - {1'b0, div_i};
      end
      q = {q[QUO_W-2:0], ge};
      r = {r[REM_W-2:0], 1'b0};
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// File: src/quad_cell_centroid_core.sv
// quad_cell_centroid_core: pipelined quad-cell flux, normalized tilts and slope-map addresses
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: ll, lr, ul, ur, grid_x, grid_y
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: flux, tilt_x, tilt_y, x_slot, y_slot
//                                              tuser: zero_flux
//  cfg      in   cfg_we_i                      cfg_wdata_i: out_map_width
//
//  one item per cycle while the output is not stalled
//  stages: pixel sums, magnitude and sign, nine divider stages, rounding and output
//  the divider retires two quotient bits per stage, which sets the depth
//  one shared enable advances every stage; it is high when the output is empty or taken
//  reset clears the valid bits and sets out_map_width to 64
`timescale 1ns / 1ps

module quad_cell_centroid_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qcc_pkg::WIDTH_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pixel_ll, pixel_lr, pixel_ul, pixel_ur, grid_x, grid_y, zero pad
  input  logic [qcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // total_flux, tilt_x, tilt_y, x_slot, y_slot, zero pad
  output logic [qcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // zero_flux
  output logic                           m_axis_tuser
);
  import qcc_pkg::*;

  logic                 en;
  logic [NSTG-1:0]      v_q;
  logic [WIDTH_W-1:0]   width_q;

  logic [PIXEL_BITS-1:0] ll, lr, ul, ur;
  logic [GRID_BITS-1:0]  gx, gy;
  logic [GRID_BITS+WIDTH_W:0] prod;

  logic [FLUX_W-1:0] flux0_q;
  logic [PAIR_W-1:0] px0_q, nx0_q, py0_q, ny0_q;
  logic [SLOT_W-1:0] xs0_q;

  side_t            side_q [1:NSTG-2];
  side_t            side1_d;
  logic [PAIR_W-1:0] mag_x_d, mag_y_d;
  logic [REM_W-1:0]  rem_x1_q, rem_y1_q;

  logic [REM_W-1:0] rem_x [DIV_STAGES];
  logic [REM_W-1:0] rem_y [DIV_STAGES];
  logic [QUO_W-1:0] quo_x [DIV_STAGES];
  logic [QUO_W-1:0] quo_y [DIV_STAGES];

  logic [FLUX_W-1:0] flux_q;
  logic [TILT_W-1:0] tx_q, ty_q;
  logic [SLOT_W-1:0] xs_q, ys_q;
  logic              zf_q;

  assign en            = m_axis_tready || !v_q[NSTG-1];
  assign s_axis_tready = en;

  assign ll = s_axis_tdata[PIXEL_BITS-1:0];
  assign lr = s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign ul = s_axis_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
  assign ur = s_axis_tdata[4*PIXEL_BITS-1:3*PIXEL_BITS];
  assign gx = s_axis_tdata[4*PIXEL_BITS+GRID_BITS-1:4*PIXEL_BITS];
  assign gy = s_axis_tdata[4*PIXEL_BITS+2*GRID_BITS-1:4*PIXEL_BITS+GRID_BITS];
  assign prod = gy * {width_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      v_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (en) begin
        v_q <= {v_q[NSTG-2:0], s_axis_tvalid};
      end
    end
  end

  // stage 0: pair sums, flux, x address
  always_ff @(posedge clk_i) begin
    if (en) begin
      flux0_q <= FLUX_W'(ll) + FLUX_W'(lr) + FLUX_W'(ul) + FLUX_W'(ur);
      px0_q   <= PAIR_W'(lr) + PAIR_W'(ur);
      nx0_q   <= PAIR_W'(ll) + PAIR_W'(ul);
      py0_q   <= PAIR_W'(ul) + PAIR_W'(ur);
      ny0_q   <= PAIR_W'(ll) + PAIR_W'(lr);
      xs0_q   <= SLOT_W'(prod + (GRID_BITS+WIDTH_W+1)'(gx));
    end
  end

  // stage 1: sign and magnitude of each numerator, y address
  always_comb begin
    side1_d.flux   = flux0_q;
    side1_d.zf     = (flux0_q == '0);
    side1_d.neg_x  = nx0_q > px0_q;
    side1_d.neg_y  = ny0_q > py0_q;
    side1_d.x_slot = xs0_q;
    side1_d.y_slot = xs0_q + SLOT_W'(width_q);
    mag_x_d = side1_d.neg_x ? nx0_q - px0_q : px0_q - nx0_q;
    mag_y_d = side1_d.neg_y ? ny0_q - py0_q : py0_q - ny0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side1_d;
      rem_x1_q  <= REM_W'(mag_x_d);
      rem_y1_q  <= REM_W'(mag_y_d);
      for (int s = 2; s <= NSTG-2; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    if (i == 0) begin : g_first
      qcc_div_stage u_div_x (
        .clk_i, .en_i(en), .rem_i(rem_x1_q), .quo_i('0), .div_i(side_q[1].flux),
        .rem_o(rem_x[i]), .quo_o(quo_x[i])
      );
      qcc_div_stage u_div_y (
        .clk_i, .en_i(en), .rem_i(rem_y1_q), .quo_i('0), .div_i(side_q[1].flux),
        .rem_o(rem_y[i]), .quo_o(quo_y[i])
      );
    end else begin : g_next
      qcc_div_stage u_div_x (
        .clk_i, .en_i(en), .rem_i(rem_x[i-1]), .quo_i(quo_x[i-1]),
        .div_i(side_q[i+1].flux), .rem_o(rem_x[i]), .quo_o(quo_x[i])
      );
      qcc_div_stage u_div_y (
        .clk_i, .en_i(en), .rem_i(rem_y[i-1]), .quo_i(quo_y[i-1]),
        .div_i(side_q[i+1].flux), .rem_o(rem_y[i]), .quo_o(quo_y[i])
      );
    end
  end

  // output stage: round half up, sign, saturate
  always_ff @(posedge clk_i) begin
    if (en) begin
      flux_q <= side_q[NSTG-2].flux;
      zf_q   <= side_q[NSTG-2].zf;
      xs_q   <= side_q[NSTG-2].x_slot;
      ys_q   <= side_q[NSTG-2].y_slot;
      tx_q   <= tilt_round(quo_x[DIV_STAGES-1], side_q[NSTG-2].neg_x, side_q[NSTG-2].zf);
      ty_q   <= tilt_round(quo_y[DIV_STAGES-1], side_q[NSTG-2].neg_y, side_q[NSTG-2].zf);
    end
  end

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = OUT_TDATA_W'({ys_q, xs_q, ty_q, tx_q, flux_q});
  assign m_axis_tuser  = zf_q;

  // rem outputs of the last stage are not needed
  logic unused_rem;
  assign unused_rem = ^{rem_x[DIV_STAGES-1], rem_y[DIV_STAGES-1]};

endmodule

// File: src/qcc_checker.sv
// qcc_checker: port-level assertions for the quad-cell centroid core, bound to the top level
`timescale 1ns / 1ps

module qcc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import qcc_pkg::*;

  logic [FLUX_W-1:0] o_flux;
  logic [TILT_W-1:0] o_tx, o_ty;

  assign o_flux = m_axis_tdata[FLUX_W-1:0];
  assign o_tx   = m_axis_tdata[FLUX_W+TILT_W-1:FLUX_W];
  assign o_ty   = m_axis_tdata[FLUX_W+2*TILT_W-1:FLUX_W+TILT_W];

  // zero flux item carries zero tilts
  a_zero_tilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> o_tx == '0 && o_ty == '0)
    else $error("zero flux item with nonzero tilt");

  // flag matches the flux
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == (o_flux == '0))
    else $error("zero_flux flag disagrees with total_flux");

  // empty output never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // stalled result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

endmodule

bind quad_cell_centroid_core qcc_checker u_qcc_checker (.*);

// File: tb/quad_cell_centroid_core_test.sv
// quad_cell_centroid_core_test: self-checking stream testbench for the quad-cell centroid core
`timescale 1ns / 1ps

module quad_cell_centroid_core_test;

  import qcc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 320;
  localparam int DRAIN_CYCLES = 20;

  // packed lowest field last, so a cast gives the tdata layout
  typedef struct packed {
    logic [GRID_BITS-1:0]  gy;
    logic [GRID_BITS-1:0]  gx;
    logic [PIXEL_BITS-1:0] ur;
    logic [PIXEL_BITS-1:0] ul;
    logic [PIXEL_BITS-1:0] lr;
    logic [PIXEL_BITS-1:0] ll;
  } spot_t;

  typedef struct packed {
    logic              zero_flux;
    logic [SLOT_W-1:0] y_slot;
    logic [SLOT_W-1:0] x_slot;
    logic [TILT_W-1:0] tilt_y;
    logic [TILT_W-1:0] tilt_x;
    logic [FLUX_W-1:0] flux;
  } centroid_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [WIDTH_W-1:0]     cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  spot_t              spot_q[$];
  centroid_t          slope_q[$];
  logic [WIDTH_W-1:0] map_width = WIDTH_RESET;
  int                 error_count = 0;
  int                 result_count = 0;
  int                 cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_pct;
  int stall_max;

  quad_cell_centroid_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // q1.15 of (pos - neg) / flux, ties away from zero, saturated
  function automatic logic [TILT_W-1:0] q15_tilt(input logic [FLUX_W-1:0] pos,
                                                 input logic [FLUX_W-1:0] neg,
                                                 input logic [FLUX_W-1:0] flux);
    logic        negative;
    logic [63:0] mag;
    logic [63:0] q;
    negative = neg > pos;
    mag = negative ? 64'(neg) - 64'(pos) : 64'(pos) - 64'(neg);
    q = (mag * 64'd65536 + 64'(flux)) / (64'd2 * 64'(flux));
    if (negative) begin
      if (q > 64'd32768) q = 64'd32768;
      q = 64'd0 - q;
    end else if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[TILT_W-1:0];
  endfunction

  function automatic centroid_t centroid_of(input spot_t s, input logic [WIDTH_W-1:0] w);
    centroid_t   c;
    logic [63:0] xs;
    c.flux = FLUX_W'(s.ll) + FLUX_W'(s.lr) + FLUX_W'(s.ul) + FLUX_W'(s.ur);
    c.zero_flux = (c.flux == '0);
    if (c.zero_flux) begin
      c.tilt_x = '0;
      c.tilt_y = '0;
    end else begin
      c.tilt_x = q15_tilt(FLUX_W'(s.lr) + FLUX_W'(s.ur), FLUX_W'(s.ll) + FLUX_W'(s.ul), c.flux);
      c.tilt_y = q15_tilt(FLUX_W'(s.ul) + FLUX_W'(s.ur), FLUX_W'(s.ll) + FLUX_W'(s.lr), c.flux);
    end
    xs = 64'(s.gy) * (64'd2 * 64'(w)) + 64'(s.gx);
    c.x_slot = xs[SLOT_W-1:0];
    c.y_slot = SLOT_W'(64'(c.x_slot) + 64'(w));
    return c;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] random_pixel(input int kind);
    logic [PIXEL_BITS-1:0] p;
    case (kind)
      0: p = PIXEL_BITS'($urandom_range(0, 3));
      1: p = PIXEL_BITS'(65535 - $urandom_range(0, 15));
      2: p = PIXEL_BITS'($urandom) & PIXEL_BITS'((1 << $urandom_range(1, PIXEL_BITS)) - 1);
      default: p = PIXEL_BITS'($urandom);
    endcase
    return p;
  endfunction

  function automatic spot_t random_spot();
    spot_t s;
    int    mode;
    int    kind;
    mode = $urandom_range(0, 99);
    kind = $urandom_range(0, 3);
    s.ll = random_pixel(kind);
    s.lr = random_pixel(kind);
    s.ul = random_pixel(kind);
    s.ur = random_pixel(kind);
    if (mode < 6) begin
      s.ll = '0; s.lr = '0; s.ul = '0; s.ur = '0;
    end else if (mode < 14) begin
      s.lr = '0; s.ur = '0;
    end else if (mode < 22) begin
      s.ll = '0; s.ul = '0;
    end else if (mode < 30) begin
      s.ll = '0; s.lr = '0;
    end else if (mode < 38) begin
      s.ul = '0; s.ur = '0;
    end else if (mode < 46) begin
      // light on a single pixel
      case ($urandom_range(0, 3))
        0: begin s.lr = '0; s.ul = '0; s.ur = '0; end
        1: begin s.ll = '0; s.ul = '0; s.ur = '0; end
        2: begin s.ll = '0; s.lr = '0; s.ur = '0; end
        default: begin s.ll = '0; s.lr = '0; s.ul = '0; end
      endcase
    end
    s.gx = ($urandom_range(0, 9) == 0) ? GRID_BITS'($urandom_range(0, 1) * 63)
                                       : GRID_BITS'($urandom_range(0, 63));
    s.gy = ($urandom_range(0, 9) == 0) ? GRID_BITS'($urandom_range(0, 1) * 63)
                                       : GRID_BITS'($urandom_range(0, 63));
    return s;
  endfunction

  task automatic push_spot(input logic [15:0] ll, input logic [15:0] lr, input logic [15:0] ul,
                           input logic [15:0] ur, input logic [5:0] gx, input logic [5:0] gy);
    spot_t s;
    s.ll = ll; s.lr = lr; s.ul = ul; s.ur = ur; s.gx = gx; s.gy = gy;
    spot_q.push_back(s);
  endtask

  task automatic load_random_spots(input int count);
    repeat (count) spot_q.push_back(random_spot());
  endtask

  task automatic wait_idle();
    while (spot_q.size() != 0 || slope_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_map_width(input logic [WIDTH_W-1:0] w);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    map_width = w;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, result_count, got, want);
    error_count++;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        slope_q.push_back(centroid_of(spot_q.pop_front(), map_width));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (spot_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_TDATA_W'(spot_q[0]);
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each item and stalls on one of four modes chosen from cycle_count
  always @(posedge clk_i) begin
    centroid_t got;
    centroid_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[OUT_W-1:0]};
        if (slope_q.size() == 0) begin
          report_mismatch("unexpected item", longint'(got.flux), -1);
        end else begin
          want = slope_q.pop_front();
          if (got.flux != want.flux)
            report_mismatch("total_flux", longint'(got.flux), longint'(want.flux));
          if (got.tilt_x != want.tilt_x)
            report_mismatch("tilt_x", longint'($signed(got.tilt_x)), longint'($signed(want.tilt_x)));
          if (got.tilt_y != want.tilt_y)
            report_mismatch("tilt_y", longint'($signed(got.tilt_y)), longint'($signed(want.tilt_y)));
          if (got.x_slot != want.x_slot)
            report_mismatch("x_slot", longint'(got.x_slot), longint'(want.x_slot));
          if (got.y_slot != want.y_slot)
            report_mismatch("y_slot", longint'(got.y_slot), longint'(want.y_slot));
          if (got.zero_flux != want.zero_flux)
            report_mismatch("zero_flux", longint'(got.zero_flux), longint'(want.zero_flux));
        end
        result_count++;
      end
      case ((cycle_count / 256) % 4)
        0: begin stall_pct = 0;  stall_max = 1;  end
        1: begin stall_pct = 30; stall_max = 2;  end
        2: begin stall_pct = 10; stall_max = 16; end
        default: begin stall_pct = 60; stall_max = 4; end
      endcase
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, stall_max - 1);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [WIDTH_W-1:0] width_plan [5];
    width_plan[0] = 7'd1;
    width_plan[1] = 7'd127;
    width_plan[2] = 7'd0;
    width_plan[3] = 7'd64;
    width_plan[4] = WIDTH_W'($urandom_range(2, 126));

    // zero flux, full scale, one lit pixel, least flux, rounding ties, bit patterns
    push_spot(16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0, 6'd0);
    push_spot(16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd63, 6'd63);
    push_spot(16'hffff, 16'hffff, 16'hffff, 16'hffff, 6'd63, 6'd63);
    push_spot(16'hffff, 16'h0000, 16'h0000, 16'h0000, 6'd0, 6'd63);
    push_spot(16'h0000, 16'hffff, 16'h0000, 16'h0000, 6'd63, 6'd0);
    push_spot(16'h0000, 16'h0000, 16'hffff, 16'h0000, 6'd1, 6'd1);
    push_spot(16'h0000, 16'h0000, 16'h0000, 16'hffff, 6'd62, 6'd31);
    push_spot(16'h0000, 16'h0000, 16'h0000, 16'h0001, 6'd5, 6'd9);
    push_spot(16'h0001, 16'h0000, 16'h0000, 16'h0000, 6'd9, 6'd5);
    push_spot(16'hffff, 16'hffff, 16'h0000, 16'h0002, 6'd10, 6'd20);
    push_spot(16'hffff, 16'hffff, 16'h0002, 16'h0000, 6'd20, 6'd10);
    push_spot(16'h0001, 16'h0001, 16'h0001, 16'h0001, 6'd33, 6'd44);
    push_spot(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 6'h2a, 6'h15);
    push_spot(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 6'h15, 6'h2a);
    push_spot(16'h0001, 16'h0002, 16'h0000, 16'h0000, 6'd3, 6'd7);
    push_spot(16'h8000, 16'h0000, 16'h0000, 16'h7fff, 6'd31, 6'd32);
    load_random_spots(PHASE_ITEMS);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    foreach (width_plan[i]) begin
      set_map_width(width_plan[i]);
      load_random_spots(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
